// File: rtl/stt_pkg.sv
// Shared types, token codes and helpers for the source text tokenizer.
// No dependencies; every other file imports this package.
package stt_pkg;

    localparam int WordChars = 7;
    localparam int QueueDepth = 4;

    typedef enum logic [5:0] {
        K_LPAREN, K_RPAREN, K_LBRACKET, K_RBRACKET, K_LBRACE, K_RBRACE,
        K_BAR, K_COMMA, K_SEMI, K_PLUS, K_MINUS, K_STAR, K_SLASH, K_CARET,
        K_PERCENT, K_QUESTION, K_NOT, K_NOTEQ, K_COLON, K_DEFINE, K_ENDDEF,
        K_EQ, K_ASSIGN, K_LT, K_LE, K_GT, K_GE, K_INTEGER, K_REAL, K_VARIABLE,
        K_STRING_CHAR, K_STRING_END, K_TRUE, K_FALSE, K_DIV, K_MOD, K_AND,
        K_OR, K_IF, K_ELSE, K_WHILE, K_LAMBDA, K_NIL, K_THIS, K_DELAY,
        K_FORCE, K_SCONS, K_SCAR, K_SCDR, K_RETURN, K_END, K_ERROR
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE, M_TILDE, M_EQUAL, M_LESS, M_GREATER, M_COLON, M_INT, M_FRAC,
        M_WORD, M_STR, M_DONE, M_HALT
    } mode_t;

    typedef struct packed {
        logic        last;
        logic [15:0] span_len;
        logic [31:0] start_pos;
        logic [15:0] line_no;
        logic [7:0]  char_out;
        logic [3:0]  frac_count;
        logic [31:0] frac_value;
        logic [31:0] int_part;
        kind_t       kind;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    typedef struct packed {
        logic       skip;
        logic       bump;
        logic [1:0] cm;
        logic       bang;
    } skip_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Whitespace and comment tracking for one byte.
    function automatic skip_t skip_byte(input logic [7:0] c, input logic [1:0] cm,
                                        input logic bang);
        skip_t s;
        s.skip = is_space(c) || (cm != 2'd0) || (c == "!");
        s.bump = s.skip && (c == 8'h0a);
        s.cm   = cm;
        s.bang = bang;
        if (s.skip) begin
            case (cm)
                2'd0: begin
                    if (c == 8'h0a) s.bang = 1'b0;
                    else if (c == "!") begin
                        if (bang) s.cm = 2'd2;
                        else begin s.bang = 1'b1; s.cm = 2'd1; end
                    end
                end
                2'd1: begin
                    if (c == 8'h0a) begin s.cm = 2'd0; s.bang = 1'b0; end
                    else if (c == "!") begin
                        if (bang) s.cm = 2'd2;
                        else begin s.cm = 2'd0; s.bang = 1'b1; end
                    end else s.bang = 1'b0;
                end
                2'd2: begin
                    if (c == 8'h0a) begin s.cm = 2'd0; s.bang = 1'b0; end
                end
                default: s.cm = 2'd0;
            endcase
        end
        return s;
    endfunction

    // Repack a right-aligned string literal first-character-lowest.
    function automatic logic [8*WordChars-1:0] kw_pack(input logic [8*WordChars-1:0] v,
                                                       input int n);
        logic [8*WordChars-1:0] o;
        o = '0;
        for (int i = 0; i < WordChars; i++) begin
            if (i < n) o[8*i +: 8] = v[8*(n-1-i) +: 8];
        end
        return o;
    endfunction

    function automatic logic kw_hit(input logic [8*WordChars-1:0] w, input logic [15:0] len,
                                    input logic [8*WordChars-1:0] v, input int n);
        return (len == 16'(n)) && (w == kw_pack(v, n));
    endfunction

    function automatic kind_t word_kind(input logic [8*WordChars-1:0] w,
                                        input logic [15:0] len);
        kind_t k;
        k = K_VARIABLE;
        if (kw_hit(w, len, 56'("true"), 4))   k = K_TRUE;
        if (kw_hit(w, len, 56'("false"), 5))  k = K_FALSE;
        if (kw_hit(w, len, 56'("div"), 3))    k = K_DIV;
        if (kw_hit(w, len, 56'("mod"), 3))    k = K_MOD;
        if (kw_hit(w, len, 56'("equals"), 6)) k = K_EQ;
        if (kw_hit(w, len, 56'("not"), 3))    k = K_NOT;
        if (kw_hit(w, len, 56'("and"), 3))    k = K_AND;
        if (kw_hit(w, len, 56'("or"), 2))     k = K_OR;
        if (kw_hit(w, len, 56'("if"), 2))     k = K_IF;
        if (kw_hit(w, len, 56'("else"), 4))   k = K_ELSE;
        if (kw_hit(w, len, 56'("while"), 5))  k = K_WHILE;
        if (kw_hit(w, len, 56'("lambda"), 6)) k = K_LAMBDA;
        if (kw_hit(w, len, 56'("nil"), 3))    k = K_NIL;
        if (kw_hit(w, len, 56'("this"), 4))   k = K_THIS;
        if (kw_hit(w, len, 56'("delay"), 5))  k = K_DELAY;
        if (kw_hit(w, len, 56'("force"), 5))  k = K_FORCE;
        if (kw_hit(w, len, 56'("scons"), 5))  k = K_SCONS;
        if (kw_hit(w, len, 56'("scar"), 4))   k = K_SCAR;
        if (kw_hit(w, len, 56'("scdr"), 4))   k = K_SCDR;
        if (kw_hit(w, len, 56'("return"), 6)) k = K_RETURN;
        return k;
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        logic [7:0] d;
        case (c)
            "n":     d = 8'd10;
            "t":     d = 8'd9;
            "b":     d = 8'd8;
            "v":     d = 8'd11;
            "f":     d = 8'd12;
            "r":     d = 8'd13;
            "a":     d = 8'd7;
            default: d = c;
        endcase
        return d;
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic [7:0] ch,
                                    input logic [31:0] ia, input logic [31:0] fa,
                                    input logic [3:0] fd, input logic [15:0] ln,
                                    input logic [31:0] ts, input logic [15:0] wl);
        res_t r;
        r = '0;
        r.kind    = k;
        r.line_no = ln;
        if (k == K_INTEGER || k == K_REAL) r.int_part = ia;
        if (k == K_REAL) begin
            r.frac_value = fa;
            r.frac_count = fd;
        end
        if (k == K_STRING_CHAR || k == K_ERROR) r.char_out = ch;
        if (k == K_VARIABLE || k == K_STRING_CHAR || k == K_STRING_END) r.start_pos = ts;
        if (k == K_VARIABLE || k == K_STRING_END) r.span_len = wl;
        return r;
    endfunction

    function automatic logic [31:0] mul10_add(input logic [31:0] a, input logic [7:0] c);
        return 32'({a, 3'b000}) + 32'({a, 1'b0}) + 32'(c - 8'd48);
    endfunction

endpackage

// File: rtl/stt_lex.sv
// Lexer state and per-byte step logic; produces up to two results a beat.
// Depends on stt_pkg.
module stt_lex (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      in_byte,
    input  logic            end_mark,
    output stt_pkg::push_t  push
);
    import stt_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [1:0]  cm_reg, cm_next;
    logic        bang_reg, bang_next, esc_reg, esc_next;
    logic [31:0] int_reg, int_next, frac_reg, frac_next;
    logic [3:0]  fd_reg, fd_next;
    logic [8*WordChars-1:0] wc_reg, wc_next;
    logic [15:0] wl_reg, wl_next, line_reg, line_next;
    logic [31:0] pos_reg, pos_next, ts_reg, ts_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            cm_reg   <= '0;
            bang_reg <= 1'b0;
            esc_reg  <= 1'b0;
            int_reg  <= '0;
            frac_reg <= '0;
            fd_reg   <= '0;
            wc_reg   <= '0;
            wl_reg   <= '0;
            line_reg <= 16'd1;
            pos_reg  <= '0;
            ts_reg   <= '0;
        end else if (step) begin
            mode_reg <= mode_next;
            cm_reg   <= cm_next;
            bang_reg <= bang_next;
            esc_reg  <= esc_next;
            int_reg  <= int_next;
            frac_reg <= frac_next;
            fd_reg   <= fd_next;
            wc_reg   <= wc_next;
            wl_reg   <= wl_next;
            line_reg <= line_next;
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
        end
    end

    always_comb begin
        logic [7:0] c;
        logic       do_idle, flush;
        kind_t      fk;
        res_t       e;
        skip_t      sk;
        c = in_byte;
        mode_next = mode_reg; cm_next = cm_reg; bang_next = bang_reg; esc_next = esc_reg;
        int_next = int_reg; frac_next = frac_reg; fd_next = fd_reg; wc_next = wc_reg;
        wl_next = wl_reg; line_next = line_reg; pos_next = pos_reg; ts_next = ts_reg;
        push = '0;
        do_idle = 1'b0;
        flush = 1'b0;
        fk = K_END;
        e = '0;
        sk = '0;

        // pending token that a mode change releases
        unique case (mode_reg)
            M_TILDE:   fk = K_NOT;
            M_EQUAL:   fk = K_EQ;
            M_LESS:    fk = K_LT;
            M_GREATER: fk = K_GT;
            M_COLON:   fk = K_COLON;
            M_INT:     fk = K_INTEGER;
            M_FRAC:    fk = K_REAL;
            M_WORD:    fk = word_kind(wc_reg, wl_reg);
            M_STR:     fk = K_STRING_END;
            default:   fk = K_END;
        endcase

        if (mode_reg == M_HALT) begin
            mode_next = M_HALT;
        end else if (mode_reg == M_DONE) begin
            push.r0 = mk_res(K_END, '0, int_reg, frac_reg, fd_reg, line_reg, ts_reg, wl_reg);
            push.n  = 2'd1;
        end else if (end_mark) begin
            if (fk != K_END) begin
                push.r0 = mk_res(fk, '0, int_reg, frac_reg, fd_reg, line_reg, ts_reg, wl_reg);
                push.r1 = mk_res(K_END, '0, int_reg, frac_reg, fd_reg, line_reg, ts_reg,
                                 wl_reg);
                push.n  = 2'd2;
            end else begin
                push.r0 = mk_res(K_END, '0, int_reg, frac_reg, fd_reg, line_reg, ts_reg,
                                 wl_reg);
                push.n  = 2'd1;
            end
            mode_next = M_DONE; cm_next = '0; bang_next = 1'b0; esc_next = 1'b0;
        end else begin
            pos_next = pos_reg + 32'd1;
            case (mode_reg)
                M_IDLE: do_idle = 1'b1;
                M_TILDE, M_EQUAL, M_LESS, M_GREATER: begin
                    if (c == "=") begin
                        case (mode_reg)
                            M_TILDE: e.kind = K_NOTEQ;
                            M_EQUAL: e.kind = K_ASSIGN;
                            M_LESS:  e.kind = K_LE;
                            default: e.kind = K_GE;
                        endcase
                        push.r0 = mk_res(e.kind, '0, int_reg, frac_reg, fd_reg, line_reg,
                                         ts_reg, wl_reg);
                        push.n = 2'd1;
                        mode_next = M_IDLE;
                    end else flush = 1'b1;
                end
                M_COLON: begin
                    sk = skip_byte(c, cm_reg, bang_reg);
                    if (sk.skip) begin
                        cm_next = sk.cm; bang_next = sk.bang;
                        if (sk.bump && line_reg != 16'hffff) line_next = line_reg + 16'd1;
                    end else if (c == "=" || c == ";") begin
                        cm_next = '0; bang_next = 1'b0;
                        push.r0 = mk_res((c == "=") ? K_DEFINE : K_ENDDEF, '0, int_reg,
                                         frac_reg, fd_reg, line_reg, ts_reg, wl_reg);
                        push.n = 2'd1;
                        mode_next = M_IDLE;
                    end else flush = 1'b1;
                end
                M_INT: begin
                    if (is_digit(c)) int_next = mul10_add(int_reg, c);
                    else if (c == ".") begin
                        mode_next = M_FRAC; frac_next = '0; fd_next = '0;
                    end else flush = 1'b1;
                end
                M_FRAC: begin
                    if (is_digit(c)) begin
                        frac_next = mul10_add(frac_reg, c);
                        if (fd_reg != 4'd15) fd_next = fd_reg + 4'd1;
                    end else flush = 1'b1;
                end
                M_WORD: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        for (int i = 0; i < WordChars; i++) begin
                            if (wl_reg == 16'(i)) wc_next[8*i +: 8] = wc_reg[8*i +: 8] | c;
                        end
                        if (wl_reg != 16'hffff) wl_next = wl_reg + 16'd1;
                    end else flush = 1'b1;
                end
                M_STR: begin
                    if (!esc_reg && c == "\"") begin
                        push.r0 = mk_res(K_STRING_END, '0, int_reg, frac_reg, fd_reg,
                                         line_reg, ts_reg, wl_reg);
                        push.n = 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        if (c == 8'h0a && line_reg != 16'hffff) line_next = line_reg + 16'd1;
                        if (esc_reg || c != "\\") begin
                            push.r0 = mk_res(K_STRING_CHAR, esc_reg ? decode_escape(c) : c,
                                             int_reg, frac_reg, fd_reg, line_next, ts_reg,
                                             wl_reg);
                            push.n = 2'd1;
                            if (wl_reg != 16'hffff) wl_next = wl_reg + 16'd1;
                            esc_next = 1'b0;
                        end else esc_next = 1'b1;
                    end
                end
                default: mode_next = M_HALT;
            endcase

            if (flush) begin
                push.r0 = mk_res(fk, '0, int_reg, frac_reg, fd_reg, line_reg, ts_reg, wl_reg);
                push.n = 2'd1;
                mode_next = M_IDLE; cm_next = '0; bang_next = 1'b0; esc_next = 1'b0;
                do_idle = 1'b1;
            end

            if (do_idle) begin
                sk = skip_byte(c, cm_next, bang_next);
                e.kind = K_END;
                if (sk.skip) begin
                    cm_next = sk.cm; bang_next = sk.bang;
                    if (sk.bump && line_next != 16'hffff) line_next = line_next + 16'd1;
                end else begin
                    cm_next = '0; bang_next = 1'b0;
                    case (c)
                        "(": e.kind = K_LPAREN;
                        ")": e.kind = K_RPAREN;
                        "[": e.kind = K_LBRACKET;
                        "]": e.kind = K_RBRACKET;
                        "{": e.kind = K_LBRACE;
                        "}": e.kind = K_RBRACE;
                        "|": e.kind = K_BAR;
                        ",": e.kind = K_COMMA;
                        ";": e.kind = K_SEMI;
                        "+": e.kind = K_PLUS;
                        "-": e.kind = K_MINUS;
                        "*": e.kind = K_STAR;
                        "/": e.kind = K_SLASH;
                        "^": e.kind = K_CARET;
                        "%": e.kind = K_PERCENT;
                        "?": e.kind = K_QUESTION;
                        "~": mode_next = M_TILDE;
                        "=": mode_next = M_EQUAL;
                        "<": mode_next = M_LESS;
                        ">": mode_next = M_GREATER;
                        ":": mode_next = M_COLON;
                        "\"": begin
                            mode_next = M_STR; esc_next = 1'b0; wl_next = '0; ts_next = pos_reg;
                        end
                        default: begin
                            if (is_digit(c)) begin
                                mode_next = M_INT; int_next = 32'(c - 8'd48);
                                frac_next = '0; fd_next = '0;
                            end else if (is_alpha(c)) begin
                                mode_next = M_WORD; wc_next = '0; wc_next[7:0] = c;
                                wl_next = 16'd1; ts_next = pos_reg;
                            end else begin
                                e.kind = K_ERROR;
                                mode_next = M_HALT;
                            end
                        end
                    endcase
                end
                if (e.kind != K_END) begin
                    e = mk_res(e.kind, c, int_next, frac_next, fd_next, line_next, ts_next,
                               wl_next);
                    if (push.n == 2'd0) push.r0 = e;
                    else push.r1 = e;
                    push.n = push.n + 2'd1;
                end
            end
        end

        if (push.n == 2'd1) push.r0.last = 1'b1;
        if (push.n == 2'd2) push.r1.last = 1'b1;
    end

endmodule

// File: rtl/stt_queue.sv
// Result queue: takes up to two results per beat, releases one per beat.
// Depends on stt_pkg.
module stt_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  stt_pkg::push_t push,
    output logic           has_room,
    output logic           rd_valid,
    input  logic           rd_ready,
    output stt_pkg::res_t  rd_data,
    output logic [2:0]     level
);
    import stt_pkg::*;

    res_t       mem_reg [QueueDepth];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic [1:0] n_in;
    logic       pop;

    assign n_in     = wr_en ? push.n : 2'd0;
    assign pop      = rd_valid && rd_ready;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign has_room = cnt_reg <= 3'd2;
    assign level    = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_in;
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            cnt_reg    <= cnt_reg + 3'(n_in) - 3'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) mem_reg[wr_ptr_reg] <= push.r0;
        if (n_in == 2'd2) mem_reg[wr_ptr_reg + 2'd1] <= push.r1;
    end

endmodule

// File: rtl/source_text_tokenizer_unit.sv
// Source text tokenizer top level: one byte per beat in, tokens out.
// Tokens go out on m_ in order, queued by the beat that completes them.
// Throughput: one input beat per cycle while the four-entry result queue has
// room for two results; one result per cycle out while m_tready is high.
// Reset (aresetn low, synchronous) clears the lexer state and the queue;
// line count restarts at one.
module source_text_tokenizer_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // in_byte
    input  logic [0:0]   s_tuser,   // end_mark
    output logic         m_tvalid,
    input  logic         m_tready,
    // token_kind, int_part, frac_value, frac_count, char_out, line_no,
    // start_pos, span_len, zero pad
    output logic [151:0] m_tdata,
    output logic         m_tlast    // last_of_step
);
    import stt_pkg::*;

    logic       step, room;
    push_t      push;
    res_t       head;
    logic [2:0] level;

    assign s_tready = room;
    assign step     = s_tvalid && s_tready;

    stt_lex u_lex (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .in_byte  (s_tdata),
        .end_mark (s_tuser[0]),
        .push     (push)
    );

    stt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (step),
        .push     (push),
        .has_room (room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head),
        .level    (level)
    );

    assign m_tdata = {6'b0, head.span_len, head.start_pos, head.line_no, head.char_out,
                      head.frac_count, head.frac_value, head.int_part, head.kind};
    assign m_tlast = head.last;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= 3'd4) else $error("result queue overrun");

    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        level > 3'd2 |-> !s_tready) else $error("beat taken without room");

    a_push_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd2 |-> (push.r1.last && !push.r0.last))
        else $error("last flag misplaced");

    a_valid_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid == (level != 3'd0)) else $error("output valid mismatch");

endmodule
